FILE: src/pn3d_pkg.sv
// Package with the constants and the permutation table of the 3D gradient noise unit.
`default_nettype none
package pn3d_pkg;

   // Default number of fraction bits of the coordinates.
   localparam int FRAC_BITS_DEFAULT = 16;

   // Register stages from an accepted request to its result strobe.
   localparam int LATENCY = 12;

   // Width of the noise result (signed Q2.16).
   localparam int NOISE_W = 19;

   // Saturation limits of the result.
   localparam int NOISE_MAX = 131071;
   localparam int NOISE_MIN = -131072;

   // Fixed 256-entry permutation table of the lattice hash.
   localparam logic [7:0] PERM_ROM [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13,
      8'd201, 8'd95, 8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225,
      8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
      8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148,
      8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
      8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
      8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87,
      8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175,
      8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
      8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
      8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
      8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
      8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73,
      8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64,
      8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202,
      8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
      8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17,
      8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
      8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110,
      8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241,
      8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
      8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45,
      8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141,
      8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180};

endpackage
`default_nettype wire

FILE: src/perlin_noise_3d_unit.sv
// Top level of the pipelined 3D improved gradient noise unit.
//
// A request carries a point (req_x_coord, req_y_coord, req_z_coord), each a
// signed fixed-point value with FRAC_BITS fraction bits. It is accepted at a
// rising edge where start is high and busy is low. busy is always low: the
// unit is a fully pipelined datapath and takes a new request in every cycle.
//
// Each request yields one result, rsp_noise_value (signed Q2.16), shown for
// exactly one cycle with rsp_strobe high, once the request has passed the pipeline.
// Results leave in request order at up to one per cycle. The receiver cannot
// stall, so nothing waits inside the unit.
//
// The pipeline depth is set by the multiplier chain: hash ROMs and the quintic
// fade take five stages (three multiplies in a row), the three blend levels
// take two stages each (multiply, then add), and one stage scales and clamps.
//
// A synchronous reset clears the stage valid bits; requests in flight are
// dropped and no strobe appears until new requests arrive.
`default_nettype none
module perlin_noise_3d_unit #(
   parameter int FRAC_BITS = pn3d_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [31:0]                  req_x_coord,
   input  wire logic signed [31:0]                  req_y_coord,
   input  wire logic signed [31:0]                  req_z_coord,
   output logic                                     rsp_strobe,
   output logic signed [pn3d_pkg::NOISE_W-1:0]      rsp_noise_value
);
   import pn3d_pkg::*;

   localparam int F   = FRAC_BITS;
   localparam int AW  = F + 5;          // fade coefficient a and b
   localparam int WW  = F + 2;          // fade weight
   localparam int VW  = F + 4;          // gradient and blend values
   localparam int DW  = VW + 1;         // blend difference
   localparam int PW  = DW + WW + 1;    // blend product
   localparam int SHR = (F >= 16) ? F - 16 : 0;
   localparam int SHL = (F >= 16) ? 0 : 16 - F;
   localparam logic signed [AW-1:0] FIFTEEN_S = AW'(15 * (1 << F));
   localparam logic signed [AW-1:0] TEN_S     = AW'(10 * (1 << F));
   localparam logic signed [VW-1:0] ONE_S     = VW'(1 << F);

   // Valid bits that travel with the data.
   logic [LATENCY:1] vld_ff, vld_in;

   // Stage 1: cell, fraction, fade coefficient and first hash level.
   logic [7:0]          cell1_ff [3];
   logic [F-1:0]        t1_ff    [3];
   logic signed [AW-1:0] a1_ff   [3];
   logic [7:0]          hx1_ff   [2];
   // Stage 2.
   logic signed [AW+F:0] at2_ff  [3];
   logic [2*F-1:0]      tt2_ff   [3];
   logic [F-1:0]        t2_ff    [3];
   logic [7:0]          cz2_ff;
   logic [7:0]          hy2_ff   [4];
   // Stage 3.
   logic signed [AW-1:0] b3_ff   [3];
   logic [2*F-1:0]      t2t3_ff  [3];
   logic [F-1:0]        t3_ff    [3];
   logic [3:0]          h3_ff    [8];
   // Stage 4.
   logic [2*F+3:0]      wp4_ff   [3];
   logic signed [VW-1:0] g4_ff   [8];
   // Stage 5.
   logic [WW-1:0]       w5_ff    [3];
   logic signed [VW-1:0] g5_ff   [8];
   // Blend stages.
   logic signed [PW-1:0] xp6_ff  [4];
   logic signed [VW-1:0] xa6_ff  [4];
   logic [WW-1:0]       w1_6_ff, w2_6_ff, w1_7_ff, w2_7_ff, w2_8_ff, w2_9_ff;
   logic signed [VW-1:0] x7_ff   [4];
   logic signed [PW-1:0] yp8_ff  [2];
   logic signed [VW-1:0] ya8_ff  [2];
   logic signed [VW-1:0] y9_ff   [2];
   logic signed [PW-1:0] rp10_ff;
   logic signed [VW-1:0] ra10_ff;
   logic signed [VW-1:0] r11_ff;
   logic signed [NOISE_W-1:0] out12_ff;

   logic [31:0] coord [3];
   assign coord[0] = req_x_coord;
   assign coord[1] = req_y_coord;
   assign coord[2] = req_z_coord;

   assign busy = 1'b0;

   // Valid shift line.
   always_comb begin
      vld_in = {vld_ff[LATENCY-1:1], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Blend helper: p + floor((q - p) * w / S) split as product then add.
   function automatic logic signed [PW-1:0] blend_mul(logic signed [VW-1:0] p,
                                                      logic signed [VW-1:0] q,
                                                      logic [WW-1:0] w);
      logic signed [DW-1:0] d;
      d = DW'(q) - DW'(p);
      return PW'(d) * PW'($signed({1'b0, w}));
   endfunction

   function automatic logic signed [VW-1:0] blend_add(logic signed [VW-1:0] p,
                                                      logic signed [PW-1:0] m);
      logic signed [PW-1:0] s;
      s = m >>> F;
      return p + VW'(s);
   endfunction

   // Gradient dot product for one corner.
   function automatic logic signed [VW-1:0] grad(logic [3:0] h,
                                                 logic signed [VW-1:0] dx,
                                                 logic signed [VW-1:0] dy,
                                                 logic signed [VW-1:0] dz);
      logic signed [VW-1:0] u, v;
      u = (h inside {[4'd0:4'd7], 4'd12, 4'd13}) ? dx : dy;
      v = (h inside {[4'd0:4'd3], 4'd12, 4'd13}) ? dy : dz;
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      return u + v;
   endfunction

   // Fade chain and hash pipeline, stages 1 to 5.
   always_ff @(posedge clock) begin
      logic signed [VW-1:0] off [3][2];
      logic signed [AW+F:0] atsh;
      for (int i = 0; i < 3; i++) begin
         // Stage 1.
         cell1_ff[i] <= coord[i][F+7:F];
         t1_ff[i]    <= coord[i][F-1:0];
         a1_ff[i]    <= AW'({coord[i][F-1:0], 2'b0}) + AW'({coord[i][F-1:0], 1'b0})
                        - FIFTEEN_S;
         // Stage 2.
         at2_ff[i]   <= (AW+F+1)'(a1_ff[i]) * (AW+F+1)'($signed({1'b0, t1_ff[i]}));
         tt2_ff[i]   <= t1_ff[i] * t1_ff[i];
         t2_ff[i]    <= t1_ff[i];
         // Stage 3.
         atsh         = at2_ff[i] >>> F;
         b3_ff[i]    <= AW'(atsh) + TEN_S;
         t2t3_ff[i]  <= tt2_ff[i][2*F-1:F] * t2_ff[i];
         t3_ff[i]    <= t2_ff[i];
         // Stage 4.
         wp4_ff[i]   <= t2t3_ff[i][2*F-1:F] * b3_ff[i][F+3:0];
         // Stage 5.
         w5_ff[i]    <= wp4_ff[i][F+WW-1:F];
         // Corner offsets on the near and far side.
         off[i][0]    = VW'({1'b0, t3_ff[i]});
         off[i][1]    = VW'({1'b0, t3_ff[i]}) - ONE_S;
      end
      // Hash levels.
      for (int b = 0; b < 2; b++) begin
         hx1_ff[b] <= PERM_ROM[req_x_coord[F+7:F] + 8'(b)];
      end
      cz2_ff <= cell1_ff[2];
      for (int j = 0; j < 4; j++) begin
         hy2_ff[j] <= PERM_ROM[hx1_ff[j & 1] + cell1_ff[1] + 8'(j >> 1)];
      end
      for (int k = 0; k < 8; k++) begin
         h3_ff[k] <= PERM_ROM[hy2_ff[k & 3] + cz2_ff + 8'(k >> 2)][3:0];
         g4_ff[k] <= grad(h3_ff[k], off[0][k & 1], off[1][(k >> 1) & 1],
                          off[2][(k >> 2) & 1]);
         g5_ff[k] <= g4_ff[k];
      end
   end

   // Trilinear blend, stages 6 to 11, and output scaling in stage 12.
   always_ff @(posedge clock) begin
      logic signed [39:0] sc;
      for (int j = 0; j < 4; j++) begin
         xp6_ff[j] <= blend_mul(g5_ff[2*j], g5_ff[2*j+1], w5_ff[0]);
         xa6_ff[j] <= g5_ff[2*j];
         x7_ff[j]  <= blend_add(xa6_ff[j], xp6_ff[j]);
      end
      w1_6_ff <= w5_ff[1];
      w2_6_ff <= w5_ff[2];
      w1_7_ff <= w1_6_ff;
      w2_7_ff <= w2_6_ff;
      w2_8_ff <= w2_7_ff;
      w2_9_ff <= w2_8_ff;
      for (int j = 0; j < 2; j++) begin
         yp8_ff[j] <= blend_mul(x7_ff[2*j], x7_ff[2*j+1], w1_7_ff);
         ya8_ff[j] <= x7_ff[2*j];
         y9_ff[j]  <= blend_add(ya8_ff[j], yp8_ff[j]);
      end
      rp10_ff <= blend_mul(y9_ff[0], y9_ff[1], w2_9_ff);
      ra10_ff <= y9_ff[0];
      r11_ff  <= blend_add(ra10_ff, rp10_ff);
      // Scale to Q2.16 and clamp.
      sc = (40'(r11_ff) >>> SHR) <<< SHL;
      if (sc > 40'(NOISE_MAX)) begin
         out12_ff <= NOISE_W'(NOISE_MAX);
      end else if (sc < 40'(NOISE_MIN)) begin
         out12_ff <= NOISE_W'(NOISE_MIN);
      end else begin
         out12_ff <= NOISE_W'(sc);
      end
   end

   assign rsp_strobe      = vld_ff[LATENCY];
   assign rsp_noise_value = out12_ff;

   // Every accepted request gives a strobe after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(LATENCY) rsp_strobe)
      else $error("request lost in pipeline");

   // No strobe without a request the fixed latency earlier.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("result without request");

   // The fade weight never exceeds one.
   a_fade_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] |-> (w5_ff[0] <= WW'(1 << F)))
      else $error("fade weight out of range");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench of the 3D gradient noise unit with an internal noise predictor.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pn3d_pkg::*;

   localparam int FB = 16;
   localparam int N_RANDOM = 750;
   localparam int LIMIT_CYCLES = 200000;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_y_coord = '0;
   logic signed [31:0] req_z_coord = '0;
   logic rsp_strobe;
   logic signed [NOISE_W-1:0] rsp_noise_value;

   point_type pending_points[$];
   logic signed [NOISE_W-1:0] expected_noise[$];
   int errors = 0;
   int checked = 0;
   int cycles = 0;
   int gap_left = 0;
   bit feeding_done = 1'b0;

   perlin_noise_3d_unit #(.FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .req_z_coord(req_z_coord), .rsp_strobe(rsp_strobe),
      .rsp_noise_value(rsp_noise_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Lattice hash and gradient dot product of one corner.
   function automatic longint corner_dot(int cx, int cy, int cz,
                                         longint dx, longint dy, longint dz);
      int h;
      longint u, v;
      h = PERM_ROM[cx & 255];
      h = PERM_ROM[(h + cy) & 255];
      h = PERM_ROM[(h + cz) & 255] & 15;
      u = (h < 8 || h == 12 || h == 13) ? dx : dy;
      if (h[0]) u = -u;
      v = (h < 4 || h == 12 || h == 13) ? dy : dz;
      if (h[1]) v = -v;
      return u + v;
   endfunction

   // Quintic fade; >>> on longint floors toward minus infinity.
   function automatic longint fade_weight(longint t);
      longint one, a, b, t2, t3;
      one = longint'(1) << FB;
      a = 6 * t - 15 * one;
      b = ((a * t) >>> FB) + 10 * one;
      t2 = (t * t) >>> FB;
      t3 = (t2 * t) >>> FB;
      return (t3 * b) >>> FB;
   endfunction

   function automatic longint mix(longint p, longint q, longint w);
      return p + (((q - p) * w) >>> FB);
   endfunction

   function automatic logic signed [NOISE_W-1:0] predict_noise(point_type pt);
      logic [31:0] c[3];
      int lat_idx[3];
      longint f0[3], f1[3], w[3], g[8];
      longint r;
      c[0] = pt.x; c[1] = pt.y; c[2] = pt.z;
      for (int i = 0; i < 3; i++) begin
         lat_idx[i] = (c[i] >> FB) & 255;
         f0[i] = longint'(c[i] & ((32'd1 << FB) - 1));
         f1[i] = f0[i] - (longint'(1) << FB);
         w[i] = fade_weight(f0[i]);
      end
      for (int i = 0; i < 8; i++) begin
         g[i] = corner_dot(lat_idx[0] + i[0], lat_idx[1] + i[1], lat_idx[2] + i[2],
                           i[0] ? f1[0] : f0[0], i[1] ? f1[1] : f0[1],
                           i[2] ? f1[2] : f0[2]);
      end
      r = mix(mix(mix(g[0], g[1], w[0]), mix(g[2], g[3], w[0]), w[1]),
              mix(mix(g[4], g[5], w[0]), mix(g[6], g[7], w[0]), w[1]), w[2]);
      r = r >>> (FB - 16);
      if (r > NOISE_MAX) r = NOISE_MAX;
      if (r < NOISE_MIN) r = NOISE_MIN;
      return r[NOISE_W-1:0];
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         1: return {16'($urandom), $urandom_range(1) ? 16'hFFFF : 16'h0000};
         2: return {16'($urandom_range(3) - 1), 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // Driver: presents queued requests with random gaps, mostly short.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_noise.push_back(predict_noise({req_x_coord, req_y_coord,
                                                    req_z_coord}));
         end
         if (start && busy) begin
            // Hold the request until it is taken.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_points.size() > 0) begin
            point_type pt;
            pt = pending_points.pop_front();
            req_x_coord <= pt.x;
            req_y_coord <= pt.y;
            req_z_coord <= pt.z;
            start <= 1'b1;
            if ($urandom_range(3) == 0) begin
               gap_left <= ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(3);
            end
         end else begin
            start <= 1'b0;
            feeding_done <= 1'b1;
         end
      end
   end

   // Monitor: checks each result strobe against the oldest expectation.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         if (expected_noise.size() == 0) begin
            $display("%0t: unexpected result %0d", $time, rsp_noise_value);
            errors <= errors + 1;
         end else begin
            logic signed [NOISE_W-1:0] want;
            want = expected_noise.pop_front();
            checked <= checked + 1;
            if (want !== rsp_noise_value) begin
               $display("%0t: noise mismatch expected %0d actual %0d", $time,
                        want, rsp_noise_value);
               errors <= errors + 1;
            end
         end
      end
   end

   initial begin
      logic [31:0] edges[6];
      edges = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h0000_FFFF, 32'h00FF_8000};
      // Directed points: extremes, pure lattice points, cell wrap, negatives.
      for (int i = 0; i < 6; i++) begin
         pending_points.push_back({edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]});
      end
      pending_points.push_back({32'h00FF_0000, 32'h00FF_FFFF, 32'h0100_0000});
      pending_points.push_back({32'hFFFF_0000, 32'hFFFE_8000, 32'hFF00_0001});
      pending_points.push_back({32'h0001_8000, 32'h0002_4000, 32'h0003_C000});
      pending_points.push_back({32'h7FFF_0000, 32'h8000_FFFF, 32'h0000_0001});
      for (int i = 0; i < N_RANDOM; i++) begin
         pending_points.push_back({rand_coord(), rand_coord(), rand_coord()});
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (!(feeding_done && expected_noise.size() == 0) && cycles < LIMIT_CYCLES)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
      end else begin
         $display("Checked %0d noise results over directed and random points", checked);
         if (errors == 0 && expected_noise.size() == 0) begin
            $display("SUCCESS");
         end else begin
            $display("FAILURE");
         end
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: perlin_noise_3d_unit.f
src/pn3d_pkg.sv
src/perlin_noise_3d_unit.sv
bench/tb_top.sv
